/* rtl/aip_pkg.sv */
`default_nettype none

package aip_pkg;

  // default page size in instruction slots
  localparam int unsigned DEFAULT_SLOTS_PER_PAGE = 1024;

  // instruction fields
  localparam logic [3:0] COND_ALWAYS = 4'hE;
  localparam logic [3:0] OP_MOV      = 4'hD;
  localparam logic [3:0] MAJOR_B     = 4'hA;
  localparam logic [3:0] MAJOR_BL    = 4'hB;
  localparam logic [3:0] REG_PC      = 4'hF;
  localparam logic [31:0] PC_BIAS    = 32'd8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_ENABLE = 2'd1;

  typedef enum logic [2:0] {
    KIND_ILLEGAL   = 3'd0,
    KIND_MOV       = 3'd1,
    KIND_CLEAR     = 3'd2,
    KIND_B         = 3'd3,
    KIND_BL        = 3'd4,
    KIND_B_SAME    = 3'd5,
    KIND_BL_SAME   = 3'd6
  } kind_t;

  // per-slot table entry
  localparam int unsigned SK_W = 2;
  typedef enum logic [SK_W-1:0] {
    SK_OTHER = 2'd0,
    SK_MOV   = 2'd1,
    SK_CLEAR = 2'd2
  } slot_kind_t;

endpackage

`default_nettype wire

/* rtl/aip_ram.sv */
`default_nettype none

module aip_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/arm_instruction_predecoder.sv */
`default_nettype none

// arm instruction predecoder: mov-immediate and b/bl forms
//
// request channel: start/busy. a request (instr_bytes, fetch_addr) is taken
// at a rising edge with start high and busy low. the word is assembled in
// the configured byte order and decoded into kind, dest_reg, imm_value,
// branch_offset, target_slot and fuse_with_prev.
// result channel: done is high for exactly one cycle with the result fields;
// the receiver cannot stall, so done is gone after that cycle; the fields hold.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. write only while no request is in flight.
// sequence: an accepted request moves to the response state, which registers
// done and the result fields. at the accepting edge the block writes this
// slot's kind and reads the previous slot from the slot kind ram; the response
// state uses that read and, on a fused move, writes the previous slot back to
// other. busy is high in the response state; the next request can be taken in
// the cycle that done is shown. reset: rst (synchronous) sets big_endian low
// and combine_enable high and starts a clearing pass over the slot kind ram,
// with busy high until every slot is cleared. SLOTS_PER_PAGE must be a power of two.

module arm_instruction_predecoder
  import aip_pkg::*;
#(
  parameter int unsigned SLOTS_PER_PAGE = aip_pkg::DEFAULT_SLOTS_PER_PAGE
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [31:0]                   instr_bytes,
  input  wire logic [31:0]                   fetch_addr,
  // configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [aip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                          cfg_data,
  // result channel
  output logic                               done,
  output aip_pkg::kind_t                     kind,
  output logic [3:0]                         dest_reg,
  output logic [31:0]                        imm_value,
  output logic signed [26:0]                 branch_offset,
  output logic [9:0]                         target_slot,
  output logic                               fuse_with_prev
);

  localparam int unsigned SLOT_W = $clog2(SLOTS_PER_PAGE);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_PAGE - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RESP
  } state_t;

  state_t state;
  logic [SLOT_W-1:0] clr_cnt;

  // config registers
  logic big_endian;
  logic combine_enable;

  // decoded request held for the response cycle
  kind_t             d_kind;
  logic [3:0]        d_dreg;
  logic [31:0]       d_imm;
  logic signed [26:0] d_boff;
  logic [9:0]        d_tslot;
  slot_kind_t        d_cur;
  logic [SLOT_W-1:0] d_slot;

  // combinational decode of the incoming request
  logic [31:0]       iw;
  logic [31:0]       in_addr;
  logic [SLOT_W-1:0] in_slot;
  logic [4:0]        rot_amt;
  logic [63:0]       rot_src;
  logic [31:0]       rot_val;
  logic [31:0]       off;
  logic [31:0]       tgt;
  logic [31:0]       tslot_wide;
  logic              samepage;
  kind_t             c_kind;
  logic [3:0]        c_dreg;
  logic [31:0]       c_imm;
  logic signed [26:0] c_boff;
  logic [9:0]        c_tslot;
  slot_kind_t        c_cur;

  logic accept;
  logic fuse_now;

  // ram ports
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [SK_W-1:0]   ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [SK_W-1:0]   ram_rdata;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    // byte order: big endian puts the first fetched byte on top
    iw = big_endian ? {instr_bytes[7:0], instr_bytes[15:8],
                       instr_bytes[23:16], instr_bytes[31:24]}
                    : instr_bytes;
    in_addr = {fetch_addr[31:2], 2'b00};
    in_slot = in_addr[SLOT_W+1:2];

    // 8-bit immediate rotated right by twice the rotate field
    rot_amt = {iw[11:8], 1'b0};
    rot_src = {24'd0, iw[7:0], 24'd0, iw[7:0]};
    rot_val = 32'(rot_src >> rot_amt);

    // word offset to byte offset, plus the pipeline bias
    off        = {{6{iw[23]}}, iw[23:0], 2'b00} + PC_BIAS;
    tgt        = in_addr + off;
    samepage   = (in_addr[31:SLOT_W+2] == tgt[31:SLOT_W+2]);
    tslot_wide = 32'(tgt[SLOT_W+1:2]);

    c_kind  = KIND_ILLEGAL;
    c_dreg  = 4'd0;
    c_imm   = 32'd0;
    c_boff  = 27'sd0;
    c_tslot = 10'd0;
    c_cur   = SK_OTHER;

    if (iw[31:28] == COND_ALWAYS) begin
      if (iw[27:26] == 2'b00) begin
        // data processing: only immediate mov without s, not to pc
        if (iw[25] && !iw[20] && (iw[24:21] == OP_MOV) && (iw[15:12] != REG_PC)) begin
          c_dreg = iw[15:12];
          if (rot_val == 32'd0) begin
            c_kind = KIND_CLEAR;
            c_cur  = SK_CLEAR;
          end else begin
            c_kind = KIND_MOV;
            c_imm  = rot_val;
            c_cur  = SK_MOV;
          end
        end
      end else if ((iw[27:24] == MAJOR_B) || (iw[27:24] == MAJOR_BL)) begin
        c_boff = signed'(off[26:0]);
        if (iw[27:24] == MAJOR_B) begin
          c_kind = samepage ? KIND_B_SAME : KIND_B;
        end else begin
          c_kind = samepage ? KIND_BL_SAME : KIND_BL;
        end
        if (samepage) begin
          c_tslot = tslot_wide[9:0];
        end
      end
    end
  end

  // previous slot read back this cycle; slot 0 has no predecessor
  assign fuse_now = combine_enable && (d_slot != '0) && (d_cur != SK_OTHER) &&
                    ((ram_rdata == SK_MOV) || (ram_rdata == SK_CLEAR));

  // one write port shared by the clearing pass, the slot record and the
  // fuse write-back of the previous slot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_slot;
    ram_wdata = SK_OTHER;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_IDLE: begin
        ram_we    = accept;
        ram_wdata = c_cur;
      end
      S_RESP: begin
        ram_we    = fuse_now;
        ram_waddr = d_slot - SLOT_W'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // read the predecessor at the accepting edge; it never equals this slot
  assign ram_raddr = in_slot - SLOT_W'(1);

  aip_ram #(
    .WIDTH (SK_W),
    .DEPTH (SLOTS_PER_PAGE)
  ) u_slot_kind_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian     <= 1'b0;
      combine_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BIG_ENDIAN) begin
        big_endian <= cfg_data;
      end else if (cfg_index == CFG_COMBINE_ENABLE) begin
        combine_enable <= cfg_data;
      end
    end
  end

  // sequencer and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SLOT_W'(1);
          if (clr_cnt == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      d_kind  <= c_kind;
      d_dreg  <= c_dreg;
      d_imm   <= c_imm;
      d_boff  <= c_boff;
      d_tslot <= c_tslot;
      d_cur   <= c_cur;
      d_slot  <= in_slot;
    end
    if (state == S_RESP) begin
      kind           <= d_kind;
      dest_reg       <= d_dreg;
      imm_value      <= d_imm;
      branch_offset  <= d_boff;
      target_slot    <= d_tslot;
      fuse_with_prev <= fuse_now;
    end
  end

  // a result only follows a response cycle
  a_done_after_resp: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_RESP))
    else $error("result strobe without a response cycle");

  // an accepted request always occupies the block next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !done))
    else $error("accepted request did not enter the response cycle");

  // fusion is only reported for moves
  a_fuse_move: assert property (@(posedge clk) disable iff (rst)
    (done && fuse_with_prev) |-> ((kind == KIND_MOV) || (kind == KIND_CLEAR)))
    else $error("fuse flagged on a non-move result");

  // a fuse write-back never lands on the slot just recorded
  a_fuse_addr: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESP) && ram_we) |-> (ram_waddr != d_slot))
    else $error("fuse write-back hit the current slot");

endmodule

`default_nettype wire
